>>> sv/whp_pkg.sv
// shared constants, types and codes for the wav header parser
package whp_pkg;

  // little-endian tags as they sit in the four-byte shift window
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagRifx = 32'h5846_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [15:0] PcmCode     = 16'h0001;
  localparam logic [15:0] ReqBits     = 16'd16;
  localparam logic [15:0] MaxChannels = 16'd2;
  localparam logic [5:0]  HdrLen      = 6'd44;
  localparam logic [32:0] SizeBias    = 33'd8;

  // byte positions at which a field has just been completed
  localparam logic [5:0] PosRiffTag  = 6'd3;
  localparam logic [5:0] PosRiffSize = 6'd7;
  localparam logic [5:0] PosWaveTag  = 6'd11;
  localparam logic [5:0] PosFmtTag   = 6'd15;
  localparam logic [5:0] PosFormat   = 6'd21;
  localparam logic [5:0] PosChannels = 6'd23;
  localparam logic [5:0] PosRate     = 6'd27;
  localparam logic [5:0] PosBits     = 6'd35;
  localparam logic [5:0] PosDataTag  = 6'd39;
  localparam logic [5:0] PosLast     = 6'd43;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StBadHeader  = 3'd1,
    StBigEndian  = 3'd2,
    StFormat     = 3'd3,
    StChannels   = 3'd4,
    StBitDepth   = 3'd5,
    StExtraChunk = 3'd6
  } status_e;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 33;
  localparam logic [CfgIdxW-1:0] CfgStrictMode = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgFileSize   = 8'd1;

  typedef struct packed {
    logic        strict_mode;
    logic [32:0] file_size;
  } cfg_t;

  typedef struct packed {
    logic       finished;
    logic [5:0] byte_pos;
  } core_stat_t;

endpackage

>>> sv/whp_if.sv
// handshake channels of the wav header parser: byte input, result output, config writes
interface whp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       first_byte;

  modport source (output valid, header_byte, first_byte, input ready);
  modport sink   (input valid, header_byte, first_byte, output ready);
endinterface

interface whp_out_if;
  logic                  valid;
  logic                  ready;
  whp_pkg::status_e      status;
  logic [1:0]            channel_count;
  logic [31:0]           sample_rate;
  logic [15:0]           sample_bits;
  logic [15:0]           format_code;
  logic [5:0]            data_offset;
  logic [31:0]           data_bytes;
  logic [30:0]           sample_count;

  modport source (output valid, status, channel_count, sample_rate, sample_bits,
                  format_code, data_offset, data_bytes, sample_count, input ready);
  modport sink   (input valid, status, channel_count, sample_rate, sample_bits,
                  format_code, data_offset, data_bytes, sample_count, output ready);
endinterface

interface whp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [whp_pkg::CfgIdxW-1:0]   index;
  logic [whp_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/whp_cfg.sv
// configuration register file: strict mode and expected file size
module whp_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  whp_cfg_if.sink         cfg_i,
  output whp_pkg::cfg_t   cfg_o
);

  logic        strict_q;
  logic [32:0] file_size_q;
  logic        wr;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q    <= 1'b1;
      file_size_q <= '0;
    end else if (wr) begin
      // writes to unknown indexes are dropped
      if (cfg_i.index == whp_pkg::CfgStrictMode) begin
        strict_q <= cfg_i.data[0];
      end else if (cfg_i.index == whp_pkg::CfgFileSize) begin
        file_size_q <= cfg_i.data;
      end
    end
  end

  assign cfg_o.strict_mode = strict_q;
  assign cfg_o.file_size   = file_size_q;

endmodule

>>> sv/whp_core.sv
// header parse state, per-byte field checks and the result register
module whp_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  whp_pkg::cfg_t         cfg_i,
  whp_in_if.sink                in_i,
  whp_out_if.source             out_o,
  output whp_pkg::core_stat_t   stat_o
);

  logic        finished_q;
  logic [5:0]  pos_q;
  logic [31:0] shift_q;
  logic [1:0]  ch_q;
  logic [31:0] rate_q;
  logic [15:0] bits_q;
  logic [15:0] fmt_q;

  logic        out_valid_q;
  whp_pkg::status_e st_q;
  logic [1:0]  ch_out_q;
  logic [31:0] rate_out_q;
  logic [15:0] bits_out_q;
  logic [15:0] fmt_out_q;
  logic [31:0] bytes_out_q;

  logic        take, live, emit;
  logic [5:0]  pos_b;
  logic [31:0] shift_b, word;
  logic [15:0] half;
  logic [1:0]  ch_b, ch_d;
  logic [31:0] rate_b, rate_d;
  logic [15:0] bits_b, bits_d, fmt_b, fmt_d;
  whp_pkg::status_e st_d;

  // result register frees up when empty or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign take = in_i.valid && in_i.ready;
  assign live = in_i.first_byte || !finished_q;

  always_comb begin
    // a start byte sees the cleared parse state
    pos_b   = in_i.first_byte ? '0 : pos_q;
    shift_b = in_i.first_byte ? '0 : shift_q;
    ch_b    = in_i.first_byte ? '0 : ch_q;
    rate_b  = in_i.first_byte ? '0 : rate_q;
    bits_b  = in_i.first_byte ? '0 : bits_q;
    fmt_b   = in_i.first_byte ? '0 : fmt_q;
    word    = {in_i.header_byte, shift_b[31:8]};
    half    = word[31:16];
    emit    = 1'b0;
    st_d    = whp_pkg::StOk;
    ch_d    = ch_b;
    rate_d  = rate_b;
    bits_d  = bits_b;
    fmt_d   = fmt_b;
    unique case (pos_b)
      whp_pkg::PosRiffTag: begin
        if (cfg_i.strict_mode) begin
          if (word == whp_pkg::TagRifx) begin
            emit = 1'b1;
            st_d = whp_pkg::StBigEndian;
          end else if (word != whp_pkg::TagRiff) begin
            emit = 1'b1;
            st_d = whp_pkg::StBadHeader;
          end
        end
      end
      whp_pkg::PosRiffSize: begin
        // size plus 8 at 33 bits, no wrap
        if (cfg_i.strict_mode && (cfg_i.file_size != ({1'b0, word} + whp_pkg::SizeBias))) begin
          emit = 1'b1;
          st_d = whp_pkg::StBadHeader;
        end
      end
      whp_pkg::PosWaveTag: begin
        if (cfg_i.strict_mode && (word != whp_pkg::TagWave)) begin
          emit = 1'b1;
          st_d = whp_pkg::StBadHeader;
        end
      end
      whp_pkg::PosFmtTag: begin
        if (cfg_i.strict_mode && (word != whp_pkg::TagFmt)) begin
          emit = 1'b1;
          st_d = whp_pkg::StBadHeader;
        end
      end
      whp_pkg::PosFormat: begin
        fmt_d = half;
        if (half != whp_pkg::PcmCode) begin
          emit = 1'b1;
          st_d = whp_pkg::StFormat;
        end
      end
      whp_pkg::PosChannels: begin
        // a rejected count is not kept
        if (half > whp_pkg::MaxChannels) begin
          emit = 1'b1;
          st_d = whp_pkg::StChannels;
        end else begin
          ch_d = half[1:0];
        end
      end
      whp_pkg::PosRate: begin
        rate_d = word;
      end
      whp_pkg::PosBits: begin
        bits_d = half;
        if (half != whp_pkg::ReqBits) begin
          emit = 1'b1;
          st_d = whp_pkg::StBitDepth;
        end
      end
      whp_pkg::PosDataTag: begin
        if (word != whp_pkg::TagData) begin
          emit = 1'b1;
          st_d = whp_pkg::StExtraChunk;
        end
      end
      whp_pkg::PosLast: begin
        emit = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finished_q <= 1'b1;
      pos_q      <= '0;
      shift_q    <= '0;
      ch_q       <= '0;
      rate_q     <= '0;
      bits_q     <= '0;
      fmt_q      <= '0;
    end else if (take && live) begin
      finished_q <= emit;
      pos_q      <= emit ? pos_b : pos_b + 6'd1;
      shift_q    <= word;
      ch_q       <= ch_d;
      rate_q     <= rate_d;
      bits_q     <= bits_d;
      fmt_q      <= fmt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= take && live && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && live && emit) begin
      st_q        <= st_d;
      ch_out_q    <= ch_d;
      rate_out_q  <= rate_d;
      bits_out_q  <= bits_d;
      fmt_out_q   <= fmt_d;
      bytes_out_q <= (st_d == whp_pkg::StOk) ? word : '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = st_q;
  assign out_o.channel_count = ch_out_q;
  assign out_o.sample_rate   = rate_out_q;
  assign out_o.sample_bits   = bits_out_q;
  assign out_o.format_code   = fmt_out_q;
  assign out_o.data_offset   = (st_q == whp_pkg::StOk) ? whp_pkg::HdrLen : '0;
  assign out_o.data_bytes    = bytes_out_q;
  assign out_o.sample_count  = bytes_out_q[31:1];

  assign stat_o.finished = finished_q;
  assign stat_o.byte_pos = pos_q;

endmodule

>>> sv/wav_header_parser_unit.sv
// top level of the wav header parser
// Parses a canonical 44-byte little-endian RIFF/WAVE header fed one byte per item; an item
// with first_byte set restarts the parse as byte 0. One byte is taken every clock cycle; the
// only limit is the single result register, which keeps accepting while its item is drained.
// One result item comes out at the first failed check or after byte 43; further bytes are
// dropped until the next start byte. strict_mode (index 0) enables the RIFF, WAVE and fmt
// tag checks and the RIFF size check against file_size (index 1). Configuration writes are
// always ready and must be done while the parser is idle.
module wav_header_parser_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  whp_in_if.sink    in_i,
  whp_out_if.source out_o,
  whp_cfg_if.sink   cfg_i
);

  whp_pkg::cfg_t       cfg;
  whp_pkg::core_stat_t stat;

  whp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  whp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o),
    .stat_o (stat)
  );

  // an ok result always carries the full offset and half the byte count
  a_ok_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == whp_pkg::StOk)) |->
    ((out_o.data_offset == whp_pkg::HdrLen) && (out_o.sample_count == out_o.data_bytes[31:1])))
    else $error("ok result with inconsistent size fields");

  // error results report no data
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != whp_pkg::StOk)) |->
    ((out_o.data_bytes == '0) && (out_o.data_offset == '0)))
    else $error("error result carries data fields");

  // a running parse never walks past the last header byte
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.finished |-> (stat.byte_pos <= whp_pkg::PosLast))
    else $error("parse position beyond header");

  // bytes while idle produce no result
  a_idle_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !in_i.first_byte && stat.finished) |=>
    (out_o.valid == $past(out_o.valid && !out_o.ready)))
    else $error("result from a byte taken while idle");

endmodule

>>> tb/wav_parse_sb_pkg.sv
// scoreboard for the wav header parser: byte-level header predictor and result checking
package wav_parse_sb_pkg;
  import whp_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [1:0]  channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [15:0] format_code;
    logic [5:0]  data_offset;
    logic [31:0] data_bytes;
    logic [30:0] sample_count;
  } hdr_result_t;

  class wav_parse_scoreboard;
    bit          strict_mode = 1'b1;
    logic [32:0] file_size = '0;

    logic [5:0]  byte_pos;
    logic [31:0] window;
    bit          finished = 1'b1;
    logic [1:0]  chans_seen;
    logic [31:0] rate_seen;
    logic [15:0] bits_seen;
    logic [15:0] fmt_seen;

    hdr_result_t pending_results[$];
    int unsigned bytes_parsed;
    int unsigned results_checked;
    int unsigned mismatch_count;

    function new();
      clear_parse();
    endfunction

    function void clear_parse();
      byte_pos   = '0;
      window     = '0;
      chans_seen = '0;
      rate_seen  = '0;
      bits_seen  = '0;
      fmt_seen   = '0;
    endfunction

    // one accepted header byte; queues the result it closes, if any
    function void note_byte(logic [7:0] b, logic first);
      logic [5:0]  p;
      logic [31:0] w;
      logic [15:0] hi;
      bit          ends_here;
      status_e     st;
      hdr_result_t r;
      if (first) begin
        clear_parse();
        finished = 1'b0;
      end else if (finished) begin
        return;
      end
      bytes_parsed++;
      p = byte_pos;
      window = {b, window[31:8]};
      w = window;
      hi = w[31:16];
      ends_here = 1'b0;
      st = StOk;
      case (p)
        PosRiffTag: begin
          if (strict_mode && w == TagRifx) begin
            ends_here = 1'b1;
            st = StBigEndian;
          end else if (strict_mode && w != TagRiff) begin
            ends_here = 1'b1;
            st = StBadHeader;
          end
        end
        PosRiffSize: begin
          // size plus 8 taken at 33 bits, no wrap
          if (strict_mode && file_size != {1'b0, w} + SizeBias) begin
            ends_here = 1'b1;
            st = StBadHeader;
          end
        end
        PosWaveTag: begin
          if (strict_mode && w != TagWave) begin
            ends_here = 1'b1;
            st = StBadHeader;
          end
        end
        PosFmtTag: begin
          if (strict_mode && w != TagFmt) begin
            ends_here = 1'b1;
            st = StBadHeader;
          end
        end
        PosFormat: begin
          fmt_seen = hi;
          if (hi != PcmCode) begin
            ends_here = 1'b1;
            st = StFormat;
          end
        end
        PosChannels: begin
          // a rejected count is not kept
          if (hi > MaxChannels) begin
            ends_here = 1'b1;
            st = StChannels;
          end else begin
            chans_seen = hi[1:0];
          end
        end
        PosRate: begin
          rate_seen = w;
        end
        PosBits: begin
          bits_seen = hi;
          if (hi != ReqBits) begin
            ends_here = 1'b1;
            st = StBitDepth;
          end
        end
        PosDataTag: begin
          if (w != TagData) begin
            ends_here = 1'b1;
            st = StExtraChunk;
          end
        end
        PosLast: begin
          ends_here = 1'b1;
        end
        default: ;
      endcase
      if (ends_here) begin
        r.status        = st;
        r.channel_count = chans_seen;
        r.sample_rate   = rate_seen;
        r.sample_bits   = bits_seen;
        r.format_code   = fmt_seen;
        r.data_offset   = (st == StOk) ? HdrLen : 6'd0;
        r.data_bytes    = (st == StOk) ? w : 32'd0;
        r.sample_count  = (st == StOk) ? w[31:1] : 31'd0;
        pending_results.push_back(r);
        finished = 1'b1;
      end else begin
        byte_pos = p + 6'd1;
      end
    endfunction

    task report_mismatch(string what);
      $display("%0t ns  mismatch: %s", $time, what);
      mismatch_count++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s is %h, predicted %h", name, got, want));
    endtask

    task check_result(hdr_result_t got);
      hdr_result_t want;
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result item with none pending, status %0d", got.status));
        return;
      end
      want = pending_results.pop_front();
      check_field("status", 32'(got.status), 32'(want.status));
      check_field("channel_count", 32'(got.channel_count), 32'(want.channel_count));
      check_field("sample_rate", got.sample_rate, want.sample_rate);
      check_field("sample_bits", 32'(got.sample_bits), 32'(want.sample_bits));
      check_field("format_code", 32'(got.format_code), 32'(want.format_code));
      check_field("data_offset", 32'(got.data_offset), 32'(want.data_offset));
      check_field("data_bytes", got.data_bytes, want.data_bytes);
      check_field("sample_count", 32'(got.sample_count), 32'(want.sample_count));
    endtask
  endclass

endpackage

>>> tb/tb_top.sv
// top-level testbench of wav_header_parser_unit: header byte streams against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import whp_pkg::*;
  import wav_parse_sb_pkg::*;

  // last field first, so byte i of the header sits at bits 8i
  typedef struct packed {
    logic [31:0] data_len;
    logic [31:0] data_tag;
    logic [15:0] bits;
    logic [15:0] align;
    logic [31:0] byte_rate;
    logic [31:0] rate;
    logic [15:0] chans;
    logic [15:0] format;
    logic [31:0] fmt_len;
    logic [31:0] fmt_tag;
    logic [31:0] wave_tag;
    logic [31:0] riff_size;
    logic [31:0] riff_tag;
  } wav_hdr_t;

  typedef enum int {
    FaultNone, FaultRiffTag, FaultRifx, FaultSize, FaultWaveTag, FaultFmtTag,
    FaultFormat, FaultChannels, FaultBits, FaultDataTag, FaultCut, FaultJunk
  } fault_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  whp_in_if  in_if ();
  whp_out_if out_if ();
  whp_cfg_if cfg_if ();

  wav_header_parser_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  wav_parse_scoreboard sb = new();

  int unsigned src_idle_pct = 11;
  int unsigned sink_idle_pct = 65;
  bit          cur_strict = 1'b1;
  logic [32:0] cur_fsize = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // input items are noted before result items within one edge
  always @(posedge clk) begin
    hdr_result_t got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_byte(in_if.header_byte, in_if.first_byte);
      if (out_if.valid && out_if.ready) begin
        got.status        = out_if.status;
        got.channel_count = out_if.channel_count;
        got.sample_rate   = out_if.sample_rate;
        got.sample_bits   = out_if.sample_bits;
        got.format_code   = out_if.format_code;
        got.data_offset   = out_if.data_offset;
        got.data_bytes    = out_if.data_bytes;
        got.sample_count  = out_if.sample_count;
        sb.check_result(got);
      end
    end
  end

  task automatic set_config(input bit strict, input logic [32:0] fsize);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CfgStrictMode;
    cfg_if.data  <= {32'd0, strict};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.strict_mode = strict;
    cfg_if.index <= CfgFileSize;
    cfg_if.data  <= fsize;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.file_size = fsize;
    cfg_if.valid <= 1'b0;
    cur_strict = strict;
    cur_fsize  = fsize;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.header_byte <= b;
    in_if.first_byte  <= first;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_header(input wav_hdr_t h, input int unsigned keep);
    for (int i = 0; i < keep; i++) send_byte(h[8*i +: 8], i == 0);
  endtask

  // wait for every pending result, then let the pipeline run dry
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic wav_hdr_t clean_header();
    wav_hdr_t h;
    h.riff_tag  = TagRiff;
    h.riff_size = (cur_fsize >= 33'd8) ? 32'(cur_fsize - 33'd8) : $urandom;
    h.wave_tag  = TagWave;
    h.fmt_tag   = TagFmt;
    if (!cur_strict && $urandom_range(0, 1)) begin
      h.riff_tag  = $urandom;
      h.riff_size = $urandom;
      h.wave_tag  = $urandom;
      h.fmt_tag   = $urandom;
    end
    h.fmt_len   = ($urandom_range(0, 3) == 0) ? $urandom : 32'd16;
    h.format    = PcmCode;
    h.chans     = 16'($urandom_range(0, 2));
    h.rate      = $urandom_range(0, 1) ? $urandom : 32'd44100;
    h.byte_rate = $urandom;
    h.align     = 16'($urandom);
    h.bits      = ReqBits;
    h.data_tag  = TagData;
    h.data_len  = $urandom;
    return h;
  endfunction

  task automatic random_sequence();
    wav_hdr_t    h;
    fault_e      f;
    int unsigned k;
    int unsigned keep;
    h = clean_header();
    keep = 44;
    k = $urandom_range(0, 21);
    f = (k <= 10) ? FaultNone : fault_e'(k - 10);
    case (f)
      FaultRiffTag:  h.riff_tag ^= 32'd1 << $urandom_range(0, 31);
      FaultRifx:     h.riff_tag = TagRifx;
      FaultSize:     h.riff_size ^= 32'd1 << $urandom_range(0, 31);
      FaultWaveTag:  h.wave_tag ^= 32'd1 << $urandom_range(0, 31);
      FaultFmtTag:   h.fmt_tag ^= 32'd1 << $urandom_range(0, 31);
      FaultFormat:   h.format ^= 16'd1 << $urandom_range(0, 15);
      FaultChannels: h.chans = 16'($urandom_range(3, 65535));
      FaultBits:     h.bits ^= 16'd1 << $urandom_range(0, 15);
      FaultDataTag:  h.data_tag ^= 32'd1 << $urandom_range(0, 31);
      FaultCut:      keep = $urandom_range(1, 43);
      FaultJunk: begin
        for (int i = 0; i < 11; i++) h[32*i +: 32] = $urandom;
      end
      default: ;
    endcase
    send_header(h, keep);
    // stray bytes: dropped after a result, parsed on after a cut header
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    wav_hdr_t    h;
    wav_hdr_t    base;
    int unsigned start_bytes;
    int unsigned start_results;
    in_if.valid       <= 1'b0;
    in_if.header_byte <= '0;
    in_if.first_byte  <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= CfgStrictMode;
    cfg_if.data       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed headers: largest fields, each status, restart mid-header
    set_config(1'b1, 33'h1_0000_0007);
    base.riff_tag  = TagRiff;
    base.riff_size = 32'hFFFF_FFFF;
    base.wave_tag  = TagWave;
    base.fmt_tag   = TagFmt;
    base.fmt_len   = 32'd16;
    base.format    = PcmCode;
    base.chans     = 16'd2;
    base.rate      = 32'hFFFF_FFFF;
    base.byte_rate = 32'd0;
    base.align     = 16'd4;
    base.bits      = ReqBits;
    base.data_tag  = TagData;
    base.data_len  = 32'hFFFF_FFFF;
    send_header(base, 44);
    h = base; h.riff_tag = TagRifx;          send_header(h, 44);
    h = base; h.riff_tag = 32'd0;            send_header(h, 44);
    h = base; h.riff_size = 32'hFFFF_FFFE;   send_header(h, 44);
    h = base; h.wave_tag = 32'd0;            send_header(h, 44);
    h = base; h.fmt_tag = 32'hFFFF_FFFF;     send_header(h, 44);
    h = base; h.format = 16'hFFFF;           send_header(h, 44);
    h = base; h.chans = 16'd3;               send_header(h, 44);
    h = base; h.chans = 16'hFFFF;            send_header(h, 44);
    h = base; h.bits = 16'd0;                send_header(h, 44);
    h = base; h.bits = 16'hFFFF;             send_header(h, 44);
    h = base; h.data_tag = 32'h5453_494C;    send_header(h, 44);
    send_header(base, 20);
    h = base; h.chans = 16'd1; h.rate = 32'd0; h.data_len = 32'd0;
    send_header(h, 44);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    settle();
    // riff size plus 8 must not wrap onto a small file size
    set_config(1'b1, 33'd7);
    send_header(base, 44);
    settle();
    set_config(1'b1, 33'd0);
    h = base; h.riff_size = 32'd0;
    send_header(h, 44);
    settle();
    // relaxed mode: RIFF, WAVE and fmt tags and size go unchecked
    set_config(1'b0, 33'd0);
    h = '0; h.riff_tag = TagRifx; h.format = PcmCode; h.bits = ReqBits; h.data_tag = TagData;
    send_header(h, 44);
    settle();

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          src_idle_pct  = 11;
          sink_idle_pct = 65;
        end
        1: begin
          src_idle_pct  = 65;
          sink_idle_pct = 11;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      case (seg)
        0: set_config(1'b1, {1'b0, 32'($urandom)} + 33'd8);
        1: set_config(1'b0, {1'b0, 32'($urandom)} + 33'd8);
        2: set_config(1'b1, 33'h1_0000_0007);
        3: set_config(1'b1, 33'd8);
        4: set_config(1'b0, 33'h1_0000_0007);
        default: set_config(1'b1, {1'b0, 32'($urandom)} + 33'd8);
      endcase
      start_bytes   = sb.bytes_parsed;
      start_results = sb.results_checked;
      while (sb.bytes_parsed - start_bytes < 40 || sb.results_checked - start_results < 2)
        random_sequence();
      settle();
    end

    if (sb.mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule
